// File: hw/rtl/sha256_byte_stream_hasher_assert.svh
// Assertion macros shared by the SHA-256 hasher RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle
`define SHA_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the following cycle
`define SHA_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sha256_pkg.sv
// Shared constants, types and round functions of the SHA-256 hasher.
// Used by sha256_core and sha256_byte_stream_hasher; no dependencies.
package sha256_pkg;

	localparam int unsigned BLOCK_BITS = 512;
	localparam int unsigned COUNT_W    = 61;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] FILL_MAX = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd7;

	typedef logic [7:0][31:0] hash_arr_t;

	typedef struct packed {
		logic start;
		logic init;
	} core_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	localparam hash_arr_t HASH_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// File: hw/rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: byte gathering, padding, digest output.
// Depends on sha256_pkg, sha256_core and sha256_byte_stream_hasher_assert.svh.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------------
//  message   | msg_valid / msg_ready        | data_byte, byte_valid, end_of_message
//  digest    | digest_valid / digest_ready  | digest_word, word_index, last_word
//
// A message item is taken when msg_valid meets msg_ready; an item completing a 64-byte
// block adds a compression (start, 64 rounds in the shared round unit, hash update).
// End of message adds one padding byte per cycle up to the block end, and one or two
// such compressions, then eight digest items; msg_ready stays low until the last is taken.
// Reset loads the initial hash and clears the counters at once; there is no clearing pass.
module sha256_byte_stream_hasher import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	`include "sha256_byte_stream_hasher_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_START,
		S_COMP,
		S_OUT
	} top_state_t;

	top_state_t            state_q;
	logic [5:0]            fill_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  end_q;
	logic                  marker_q;
	logic                  len_ok_q;
	logic [2:0]            word_q;
	logic [BLOCK_BITS-1:0] block_q;

	core_cmd_t  core_cmd;
	core_stat_t core_stat;
	hash_arr_t  hash;

	logic        accept;
	logic        take_byte;
	logic [63:0] total_bits;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic        shift_en;
	logic [7:0]  shift_byte;
	logic        word_take;

	assign msg_ready = (state_q == S_IDLE);
	assign accept    = msg_valid && msg_ready;
	assign take_byte = accept && byte_valid;

	// Pick the next padding byte: marker, zero fill, or big-endian length
	always_comb begin
		total_bits = {count_q, 3'b000};
		len_sel    = ~fill_q[2:0];
		len_byte   = total_bits[{len_sel, 3'b000} +: 8];
		if (!marker_q) begin
			pad_byte = PAD_MARK;
		end else if (len_ok_q && fill_q >= LEN_POS) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign shift_en   = take_byte || (state_q == S_PAD);
	assign shift_byte = (state_q == S_PAD) ? pad_byte : data_byte;
	assign word_take  = digest_valid && digest_ready;

	// Shift message and padding bytes into the block register
	always_ff @(posedge clk) begin
		if (shift_en) begin
			block_q <= {block_q[BLOCK_BITS-9:0], shift_byte};
		end
	end

	// Sequence byte gathering, padding, compression and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			count_q  <= '0;
			end_q    <= 1'b0;
			marker_q <= 1'b0;
			len_ok_q <= 1'b0;
			word_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take_byte) begin
						count_q <= count_q + COUNT_W'(1);
						fill_q  <= fill_q + 6'd1;
					end
					if (accept) begin
						end_q    <= end_of_message;
						marker_q <= 1'b0;
						len_ok_q <= 1'b0;
						if (take_byte && fill_q == FILL_MAX) begin
							state_q <= S_START;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (!marker_q) begin
						marker_q <= 1'b1;
						len_ok_q <= (fill_q < LEN_POS);
					end
					if (fill_q == FILL_MAX) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_COMP;
				end
				S_COMP: begin
					if (core_stat.done) begin
						if (!end_q) begin
							state_q <= S_IDLE;
						end else if (marker_q && len_ok_q) begin
							word_q  <= '0;
							state_q <= S_OUT;
						end else begin
							len_ok_q <= marker_q;
							state_q  <= S_PAD;
						end
					end
				end
				S_OUT: begin
					if (word_take) begin
						word_q <= word_q + 3'd1;
						if (word_q == LAST_IDX) begin
							end_q    <= 1'b0;
							marker_q <= 1'b0;
							len_ok_q <= 1'b0;
							count_q  <= '0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Drive the shared compression engine
	assign core_cmd.start = (state_q == S_START);
	assign core_cmd.init  = word_take && (word_q == LAST_IDX);

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (core_cmd),
		.block  (block_q),
		.stat   (core_stat),
		.hash   (hash)
	);

	// Present digest words from the settled hash
	assign digest_valid = (state_q == S_OUT);
	assign digest_word  = hash[word_q];
	assign word_index   = word_q;
	assign last_word    = (word_q == LAST_IDX);

	`SHA_CHECK(a_out_blocks_in, digest_valid, !msg_ready, "message taken during digest output")
	`SHA_CHECK(a_start_idle, core_cmd.start, !core_stat.busy, "compression started while busy")
	`SHA_CHECK(a_out_fill_zero, digest_valid, fill_q == 6'd0, "digest with partial block held")
	`SHA_CHECK_NEXT(a_last_ends, word_take && last_word, !digest_valid && msg_ready, "output not closed after last word")
	`SHA_CHECK_NEXT(a_done_idle, core_stat.done, !core_stat.busy, "engine busy after hash update")

endmodule

// File: hw/rtl/sha256_core.sv
// SHA-256 compression engine: one round per cycle through a shared round unit,
// with a 16-word message schedule window. Depends on sha256_pkg.
module sha256_core import sha256_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  core_cmd_t             cmd,
	input  logic [BLOCK_BITS-1:0] block,
	output core_stat_t            stat,
	output hash_arr_t             hash
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_ROUND,
		C_FINAL
	} core_state_t;

	core_state_t      state_q;
	logic [5:0]       round_q;
	hash_arr_t        hash_q;
	logic [15:0][31:0] w_q;
	hash_arr_t        r_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_next;
	hash_arr_t   r_next;

	// One round of the compression and one step of the schedule
	always_comb begin
		t1 = r_q[7] + big1(r_q[4]) + choose(r_q[4], r_q[5], r_q[6])
			+ ROUND_K[round_q] + w_q[0];
		t2 = big0(r_q[0]) + major(r_q[0], r_q[1], r_q[2]);
		w_next = w_q[0] + small0(w_q[1]) + w_q[9] + small1(w_q[14]);
		r_next = {r_q[6], r_q[5], r_q[4], r_q[3] + t1, r_q[2], r_q[1], r_q[0], t1 + t2};
	end

	// Sequence the rounds and fold the result into the running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			hash_q  <= HASH_INIT;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (cmd.init) begin
						hash_q <= HASH_INIT;
					end
					if (cmd.start) begin
						round_q <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == FILL_MAX) begin
						state_q <= C_FINAL;
					end
				end
				C_FINAL: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + r_q[i];
					end
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Load the block and working words on start, advance them each round
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && cmd.start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block[32*(15-i) +: 32];
			end
			r_q <= hash_q;
		end else if (state_q == C_ROUND) begin
			w_q <= {w_next, w_q[15:1]};
			r_q <= r_next;
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = (state_q == C_FINAL);
	assign hash      = hash_q;

endmodule

// File: dv/sha256_digest_predictor_pkg.sv
`timescale 1ns / 100ps
// Digest predictor and scoreboard for the SHA-256 byte stream hasher testbench.
// Self-contained: its own SHA-256 round constants and compression, no RTL package needed.
package sha256_digest_predictor_pkg;

	localparam bit [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam bit [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam bit [7:0] PAD_BYTE  = 8'h80;
	localparam int       LEN_FIELD = 56;
	localparam bit [2:0] FINAL_POS = 3'd7;

	typedef struct {
		bit [31:0] word;
		bit [2:0]  pos;
		bit        last;
	} digest_item_t;

	function automatic bit [31:0] rotr32(input bit [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	class digest_predictor;
		bit [31:0]    hash_state [8];
		bit [7:0]     block [64];
		int unsigned  block_fill;
		bit [63:0]    bits_done;
		digest_item_t expected_q [$];
		int unsigned  mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		// Return to the initial hash with empty counters
		function void restart();
			hash_state = START_HASH;
			block_fill = 0;
			bits_done  = '0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Fold the current 64-byte block into the running hash
		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] s0;
			bit [31:0] s1;
			bit [31:0] t1;
			bit [31:0] t2;
			int t;
			for (t = 0; t < 16; t++)
				w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
			for (t = 16; t < 64; t++) begin
				s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
				s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
				w[t] = w[t-16] + s0 + w[t-7] + s1;
			end
			v = hash_state;
			for (t = 0; t < 64; t++) begin
				t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
				t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (t = 0; t < 8; t++)
				hash_state[t] += v[t];
		endfunction

		// Take one accepted message item; queue the eight digest words at end of message
		function void note_item(input bit [7:0] data, input bit has_byte, input bit ends);
			bit [63:0] total;
			int i;
			if (has_byte) begin
				block[block_fill] = data;
				block_fill++;
				if (block_fill == 64) begin
					compress();
					bits_done += 64'd512;
					block_fill = 0;
				end
			end
			if (!ends)
				return;
			total = bits_done + 64'(block_fill) * 64'd8;
			i = block_fill;
			block[i] = PAD_BYTE;
			i++;
			// spill into a second block when the length field no longer fits
			if (i > LEN_FIELD) begin
				while (i < 64) begin
					block[i] = 8'h00;
					i++;
				end
				compress();
				i = 0;
			end
			while (i < LEN_FIELD) begin
				block[i] = 8'h00;
				i++;
			end
			for (i = 0; i < 8; i++)
				block[63 - i] = total[8*i +: 8];
			compress();
			for (i = 0; i < 8; i++)
				expected_q.push_back('{word: hash_state[i], pos: 3'(i),
					last: (3'(i) == FINAL_POS)});
			restart();
		endfunction

		task report_mismatch(input string what);
			mismatches++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		// Compare one accepted digest item with the oldest expected word
		task check_digest(input logic [31:0] word, input logic [2:0] pos, input logic last);
			digest_item_t exp_item;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("digest item %h idx %0d last %b with nothing expected",
					word, pos, last));
				return;
			end
			exp_item = expected_q.pop_front();
			if (word !== exp_item.word)
				report_mismatch($sformatf("digest_word %h, expected %h (idx %0d)",
					word, exp_item.word, exp_item.pos));
			if (pos !== exp_item.pos)
				report_mismatch($sformatf("word_index %0d, expected %0d", pos, exp_item.pos));
			if (last !== exp_item.last)
				report_mismatch($sformatf("last_word %b, expected %b (idx %0d)",
					last, exp_item.last, exp_item.pos));
		endtask
	endclass

endpackage

// File: dv/tb_sha256_byte_stream_hasher.sv
`timescale 1ns / 100ps
// Top-level testbench of sha256_byte_stream_hasher: drives message items, checks digests.
// Depends on sha256_digest_predictor_pkg and the hasher RTL.
module tb_sha256_byte_stream_hasher;
	import sha256_digest_predictor_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 140;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned DRAIN_CYCLES  = 300;
	localparam int unsigned EDGE_LENS [11] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

	logic        clk;
	logic        arst_n;
	logic        msg_valid;
	logic        msg_ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        end_of_message;
	logic        digest_valid;
	logic        digest_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_predictor sb;
	int unsigned     send_idle_pct;
	int unsigned     recv_stall_pct;
	int unsigned     hold_req;
	int unsigned     items_sent;

	sha256_byte_stream_hasher i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_ready   (digest_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run
	initial begin
		#2_000_000;
		$display("sha256_byte_stream_hasher test failed");
		$finish;
	end

	// Drive digest_ready: random stalls, plus a long hold-off on request
	initial begin : digest_sink
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		digest_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				digest_ready <= 1'b0;
				hold_left--;
			end else begin
				digest_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check every accepted digest item
	always @(posedge clk) begin
		if (arst_n && digest_valid === 1'b1 && digest_ready === 1'b1)
			sb.check_digest(digest_word, word_index, last_word);
	end

	// Offer one item after a random gap and hold it until accepted; enter and leave at negedge
	task automatic send_item(input logic [7:0] data, input logic has_byte, input logic ends);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid      <= 1'b1;
		data_byte      <= data;
		byte_valid     <= has_byte;
		end_of_message <= ends;
		do
			@(posedge clk);
		while (msg_ready !== 1'b1);
		sb.note_item(data, has_byte, ends);
		@(negedge clk);
	endtask

	// Send a message of random bytes, ending on the last byte or with a separate end item
	task automatic send_message(input int unsigned len, input bit end_with_byte);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				items_sent++;
			end
			send_item(8'($urandom_range(255)), 1'b1, end_with_byte && (i == len - 1));
			items_sent++;
		end
		if (!end_with_byte || len == 0) begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			items_sent++;
		end
	endtask

	// Mostly short messages, some around the padding and block boundaries
	task automatic run_random_phase(input int unsigned quota);
		int unsigned first_item;
		int unsigned pick;
		int unsigned len;
		first_item = items_sent;
		while (items_sent - first_item < quota) begin
			pick = $urandom_range(99);
			if (pick < 65)
				len = $urandom_range(12);
			else if (pick < 85)
				len = EDGE_LENS[$urandom_range(10)];
			else
				len = $urandom_range(100, 13);
			send_message(len, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		sb             = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 0;
		items_sent     = 0;
		arst_n         = 1'b0;
		msg_valid      = 1'b0;
		data_byte      = 8'h00;
		byte_valid     = 1'b0;
		end_of_message = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle item, empty message, "abc", extremes, end without byte
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h5a, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);

		// No idling; hold off the digest side so the block fills and stalls its input
		hold_req <= hold_req + 1;
		send_message(64, 1'b1);
		send_message(55, 1'b1);
		send_message(56, 1'b0);
		run_random_phase(RANDOM_ITEMS / 4 > 180 ? 0 : 20);

		// Sender mostly idle
		send_idle_pct  = 88;
		recv_stall_pct = 0;
		run_random_phase(RANDOM_ITEMS / 4);

		// Receiver mostly stalling
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		run_random_phase(RANDOM_ITEMS / 4);

		// Both sides idling at random
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		run_random_phase(RANDOM_ITEMS / 4);
		msg_valid <= 1'b0;

		// Drain, then watch for stray digest items
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("sha256_byte_stream_hasher test passed");
		else
			$display("sha256_byte_stream_hasher test failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_core.sv
hw/rtl/sha256_byte_stream_hasher.sv
dv/sha256_digest_predictor_pkg.sv
dv/tb_sha256_byte_stream_hasher.sv
